// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising clock edge outside reset
`define LKD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LKD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LKD_ASSERT_NOW(name, ante, cons, msg)
`define LKD_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/lkd_pkg.sv
// types, command bytes and segment table for the display link sequencer
`default_nettype none

package lkd_pkg;

  typedef enum logic [1:0] {
    KIND_UPDATE    = 2'd0,
    KIND_READ      = 2'd1,
    KIND_BYTE_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'b001,
    OP_WRITE = 3'b010,
    OP_READ  = 3'b100
  } op_e;

  localparam int unsigned NumDigits = 8;
  localparam int unsigned NumKeyRegs = 3;

  localparam logic [7:0] CmdDataWrite = 8'h40;
  localparam logic [7:0] CmdDataRead  = 8'h42;
  localparam logic [7:0] CmdAddrBase  = 8'hC0;
  localparam logic [7:0] CmdDisplayOn = 8'h8F;
  localparam logic [7:0] DummyByte    = 8'h00;

  localparam logic [4:0] StepFirst    = 5'd0;
  localparam logic [4:0] StepDataLast = 5'd16;
  localparam logic [4:0] StepCtrl     = 5'd17;
  localparam logic [4:0] StepWriteEnd = 5'd18;
  localparam logic [4:0] StepKeyLast  = 5'd3;

  typedef struct packed {
    logic [7:0] key_status;
    logic       done_res;
    logic [7:0] send_byte;
    logic       send_valid;
    logic       read_mode;
    logic       strobe_release;
    logic       strobe_pulse;
    logic       strobe_assert;
  } result_t;

  typedef struct packed {
    logic       emit;
    logic       digit_we;
    logic       key_we;
    logic [1:0] key_idx;
  } step_ctrl_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lkd_step.sv
// next-state and result logic for one request against the sequencer state
`default_nettype none

module lkd_step import lkd_pkg::*; (
  input  logic [1:0]                 kind_i,
  input  logic [7:0]                 read_byte_i,
  input  op_e                        op_i,
  input  logic [4:0]                 step_i,
  input  logic [NumDigits-1:0][3:0]  digit_i,
  input  logic [7:0]                 led_i,
  input  logic [NumKeyRegs-1:0][7:0] key_i,
  output op_e                        op_o,
  output logic [4:0]                 step_o,
  output step_ctrl_t                 ctrl_o,
  output result_t                    res_o
);

  logic [4:0] step_m1;
  logic [2:0] pair_idx;
  logic [7:0] status;

  assign step_m1  = step_i - 5'd1;
  assign pair_idx = step_m1[3:1];
  assign status   = key_i[0] | {key_i[1][6:0], 1'b0} | {key_i[2][5:0], 2'b0}
                  | {read_byte_i[4:0], 3'b0};

  always_comb begin
    op_o           = op_i;
    step_o         = step_i;
    res_o          = '0;
    ctrl_o         = '0;
    ctrl_o.key_idx = step_m1[1:0];
    case (kind_i)
      KIND_UPDATE, KIND_READ: begin
        if (op_i == OP_IDLE) begin
          ctrl_o.emit         = 1'b1;
          step_o              = StepFirst;
          res_o.strobe_assert = 1'b1;
          res_o.send_valid    = 1'b1;
          if (kind_i == KIND_UPDATE) begin
            op_o            = OP_WRITE;
            ctrl_o.digit_we = 1'b1;
            res_o.send_byte = CmdDataWrite;
          end else begin
            op_o            = OP_READ;
            res_o.send_byte = CmdDataRead;
          end
        end
      end
      KIND_BYTE_DONE: begin
        if (op_i != OP_IDLE) begin
          ctrl_o.emit = 1'b1;
          step_o      = step_i + 5'd1;
          unique case (op_i)
            OP_WRITE: begin
              if (step_i == StepFirst) begin
                res_o.strobe_pulse = 1'b1;
                res_o.send_valid   = 1'b1;
                res_o.send_byte    = CmdAddrBase;
              end else if (step_i <= StepDataLast) begin
                res_o.send_valid = 1'b1;
                // odd steps carry segments, even steps the led bit
                if (step_i[0]) begin
                  res_o.send_byte = seg_of(digit_i[pair_idx]);
                end else begin
                  res_o.send_byte = {7'b0, led_i[pair_idx]};
                end
              end else if (step_i == StepCtrl) begin
                res_o.strobe_pulse = 1'b1;
                res_o.send_valid   = 1'b1;
                res_o.send_byte    = CmdDisplayOn;
              end else begin
                op_o                 = OP_IDLE;
                step_o               = StepFirst;
                res_o.strobe_release = 1'b1;
                res_o.done_res       = 1'b1;
              end
            end
            OP_READ: begin
              if (step_i == StepFirst) begin
                res_o.read_mode  = 1'b1;
                res_o.send_valid = 1'b1;
                res_o.send_byte  = DummyByte;
              end else if (step_i <= StepKeyLast) begin
                ctrl_o.key_we    = 1'b1;
                res_o.send_valid = 1'b1;
                res_o.send_byte  = DummyByte;
              end else begin
                op_o                 = OP_IDLE;
                step_o               = StepFirst;
                res_o.strobe_release = 1'b1;
                res_o.done_res       = 1'b1;
                res_o.key_status     = status;
              end
            end
            default: begin
              ctrl_o.emit = 1'b0;
              step_o      = step_i;
            end
          endcase
        end
      end
      default: begin
        // unused kind code is dropped
        ctrl_o.emit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/led_key_display_link_sequencer.sv
// top level of the display and key link sequencer
//
//  channel   group    tuser      tdata (low bit first)
//  request   s_axis   kind[1:0]  digits_packed[31:0] led_bits[39:32] read_byte[47:40]
//  result    m_axis   -          strobe_assert, strobe_pulse, strobe_release,
//                                read_mode, send_valid, send_byte[12:5],
//                                done_res[13], key_status[21:14], zero pad
//
// one request per cycle while the result side does not stall; each request passes
// through the input register, then the step logic, then the result register
// reset returns the sequence to idle with the step count and led bits cleared
// a held result stalls the input register only when the next request yields a result
// requests that yield nothing pass through without waiting on the result side
`default_nettype none
`include "assert_macros.svh"

module led_key_display_link_sequencer import lkd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // digits_packed, led_bits, read_byte
  input  logic [1:0]  s_axis_tuser_i,  // kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // strobe_assert .. key_status, zero pad
);

  logic        in_valid_q;
  logic [47:0] in_data_q;
  logic [1:0]  in_kind_q;

  op_e                        op_q, op_d;
  logic [4:0]                 step_q, step_d;
  logic [NumDigits-1:0][3:0]  digit_q;
  logic [7:0]                 led_q;
  logic [NumKeyRegs-1:0][7:0] key_q;

  logic       out_valid_q;
  result_t    res_q, res_d;
  step_ctrl_t ctrl;
  logic       advance;
  logic       take_in;

  lkd_step u_step (
    .kind_i      (in_kind_q),
    .read_byte_i (in_data_q[47:40]),
    .op_i        (op_q),
    .step_i      (step_q),
    .digit_i     (digit_q),
    .led_i       (led_q),
    .key_i       (key_q),
    .op_o        (op_d),
    .step_o      (step_d),
    .ctrl_o      (ctrl),
    .res_o       (res_d)
  );

  assign advance         = in_valid_q && (!ctrl.emit || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_IDLE;
      step_q      <= '0;
      led_q       <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        op_q   <= op_d;
        step_q <= step_d;
        if (ctrl.digit_we) begin
          led_q <= in_data_q[39:32];
        end
      end
      if (advance && ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_data_q <= s_axis_tdata_i;
      in_kind_q <= s_axis_tuser_i;
    end
    if (advance && ctrl.emit) begin
      res_q <= res_d;
    end
    if (advance && ctrl.digit_we) begin
      digit_q <= in_data_q[31:0];
    end
    if (advance && ctrl.key_we) begin
      key_q[ctrl.key_idx] <= in_data_q[47:40];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b0, res_q};

  `LKD_ASSERT_NOW(a_idle_step_zero, op_q == OP_IDLE, step_q == StepFirst, "idle with nonzero step")
  `LKD_ASSERT_NOW(a_write_step_range, op_q == OP_WRITE, step_q <= StepWriteEnd, "write step overrun")
  `LKD_ASSERT_NOW(a_open_from_idle, advance && ctrl.emit && res_d.strobe_assert, op_q == OP_IDLE, "strobe opened while busy")
  `LKD_ASSERT_NEXT(a_done_goes_idle, advance && ctrl.emit && res_d.done_res, op_q == OP_IDLE, "done without return to idle")

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for the display and key link sequencer: scoreboard with predictor and stream drivers
`timescale 1ns / 1ps

module tb;
  import lkd_pkg::*;

  localparam logic [1:0] KindSpare = 2'd3;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ResultTarget = 760;

  // predicts the sequencer's results and checks them in order
  class display_link_model;
    op_e        op_state = OP_IDLE;
    logic [4:0] step = '0;
    logic [3:0] digit_q [NumDigits];
    logic [7:0] led_q = '0;
    logic [7:0] key_q [NumKeyRegs];
    result_t    pending [$];
    int         errors = 0;
    logic [7:0] seg_rom [16] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                                 8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71};

    function result_t make_res(bit sa, bit sp, bit sr, bit rm, bit sv, logic [7:0] sb,
                               bit dn, logic [7:0] ks);
      result_t r;
      r.strobe_assert  = sa;
      r.strobe_pulse   = sp;
      r.strobe_release = sr;
      r.read_mode      = rm;
      r.send_valid     = sv;
      r.send_byte      = sb;
      r.done_res       = dn;
      r.key_status     = ks;
      return r;
    endfunction

    function void note_request(logic [1:0] kind, logic [31:0] digits, logic [7:0] leds,
                               logic [7:0] rbyte);
      logic [4:0] s;
      logic [2:0] idx;
      logic [7:0] status;
      if (kind == KIND_UPDATE || kind == KIND_READ) begin
        if (op_state != OP_IDLE) return;
        step = '0;
        if (kind == KIND_UPDATE) begin
          for (int i = 0; i < NumDigits; i++) digit_q[i] = digits[4*i +: 4];
          led_q = leds;
          op_state = OP_WRITE;
          pending.push_back(make_res(1, 0, 0, 0, 1, CmdDataWrite, 0, 8'h00));
        end else begin
          op_state = OP_READ;
          pending.push_back(make_res(1, 0, 0, 0, 1, CmdDataRead, 0, 8'h00));
        end
        return;
      end
      if (kind != KIND_BYTE_DONE || op_state == OP_IDLE) return;
      s = step;
      step = s + 5'd1;
      if (op_state == OP_WRITE) begin
        if (s == 5'd0) begin
          pending.push_back(make_res(0, 1, 0, 0, 1, CmdAddrBase, 0, 8'h00));
        end else if (s <= 5'd16) begin
          idx = 3'((s - 5'd1) >> 1);
          // odd steps carry the segment pattern, even steps the led bit
          if (s[0])
            pending.push_back(make_res(0, 0, 0, 0, 1, seg_rom[digit_q[idx]], 0, 8'h00));
          else
            pending.push_back(make_res(0, 0, 0, 0, 1, {7'd0, led_q[idx]}, 0, 8'h00));
        end else if (s == 5'd17) begin
          pending.push_back(make_res(0, 1, 0, 0, 1, CmdDisplayOn, 0, 8'h00));
        end else begin
          op_state = OP_IDLE;
          step = '0;
          pending.push_back(make_res(0, 0, 1, 0, 0, 8'h00, 1, 8'h00));
        end
        return;
      end
      if (s == 5'd0) begin
        pending.push_back(make_res(0, 0, 0, 1, 1, DummyByte, 0, 8'h00));
      end else if (s <= 5'd3) begin
        key_q[s - 5'd1] = rbyte;
        pending.push_back(make_res(0, 0, 0, 0, 1, DummyByte, 0, 8'h00));
      end else begin
        status = key_q[0] | (key_q[1] << 1) | (key_q[2] << 2) | (rbyte << 3);
        op_state = OP_IDLE;
        step = '0;
        pending.push_back(make_res(0, 0, 1, 0, 0, 8'h00, 1, status));
      end
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] data);
      result_t got;
      result_t want;
      got = result_t'(data[21:0]);
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      cmp_field("strobe_assert", 8'(want.strobe_assert), 8'(got.strobe_assert));
      cmp_field("strobe_pulse", 8'(want.strobe_pulse), 8'(got.strobe_pulse));
      cmp_field("strobe_release", 8'(want.strobe_release), 8'(got.strobe_release));
      cmp_field("read_mode", 8'(want.read_mode), 8'(got.read_mode));
      cmp_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
      cmp_field("send_byte", want.send_byte, got.send_byte);
      cmp_field("done_res", 8'(want.done_res), 8'(got.done_res));
      cmp_field("key_status", want.key_status, got.key_status);
      cmp_field("pad", 8'd0, 8'(data[23:22]));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [47:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;

  display_link_model sb;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_count = 0;
  int unsigned results_due = 0;

  led_key_display_link_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // request and result monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_valid && s_ready)
      sb.note_request(s_user, s_data[31:0], s_data[39:32], s_data[47:40]);
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // receiver: stall phases of random shape, plus one long hold-off
  initial begin
    int unsigned mode;
    int unsigned len;
    bit held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && cycle_count > 300) begin
        held = 1;
        repeat (HoldCycles) begin
          @(negedge clk_i);
          m_ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(10, 80);
      for (int i = 0; i < len; i++) begin
        @(negedge clk_i);
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= 1'($urandom_range(0, 1));
          2: m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= (i % 3 == 0);
        endcase
      end
    end
  end

  task automatic put_request(logic [1:0] kind, logic [31:0] digits, logic [7:0] leds,
                             logic [7:0] rbyte);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {rbyte, leds, digits};
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic put_byte_done(logic [7:0] rbyte);
    put_request(KIND_BYTE_DONE, $urandom, 8'($urandom_range(0, 255)), rbyte);
  endtask

  // stray items: a spare kind, or an update or read that the block ignores while busy
  task automatic put_noise();
    case ($urandom_range(0, 3))
      0: put_request(KIND_UPDATE, $urandom, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      1: put_request(KIND_READ, $urandom, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      default: put_request(KindSpare, $urandom, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic run_sequence(logic [1:0] kind, int unsigned steps);
    put_request(kind, $urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 11) == 0) put_noise();
      put_byte_done(8'($urandom_range(0, 255)));
    end
    results_due += steps + 1;
  endtask

  initial begin
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // byte done and spare kind while idle, then an update with busy starts on top
    put_request(KIND_BYTE_DONE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    put_request(KindSpare, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    put_request(KIND_UPDATE, 32'h0000_0000, 8'hFF, 8'h00);
    put_request(KIND_READ, 32'hFFFF_FFFF, 8'h00, 8'hFF);
    put_request(KIND_UPDATE, 32'hFFFF_FFFF, 8'h00, 8'hFF);
    put_request(KindSpare, 32'h0000_0000, 8'h00, 8'h00);
    for (int i = 0; i < 18; i++) put_byte_done(8'hFF);
    // key read request sent before the update has returned to idle
    put_request(KIND_READ, 32'h0000_0000, 8'h00, 8'h00);
    for (int i = 0; i < 4; i++) put_byte_done(8'hFF);

    while (results_due < ResultTarget) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 0) put_byte_done(8'($urandom_range(0, 255)));
        else put_request(KindSpare, $urandom, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) run_sequence(KIND_UPDATE, 18);
      else run_sequence(KIND_READ, 4);
    end

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lkd_pkg.sv
rtl/lkd_step.sv
rtl/led_key_display_link_sequencer.sv
test/tb.sv
